// ===== rtl/core/sbcf_pkg.sv =====
// ============================================================================
// sbcf_pkg - servo bus command framer package
// Shared types and frame constants for the framer core and its cell chain.
// ============================================================================
`default_nettype none

package sbcf_pkg;

  // Frame geometry
  localparam int unsigned FrameMax  = 13;
  localparam int unsigned FrameLenW = $clog2(FrameMax + 1);

  // Total frame lengths, header and checksum included
  localparam logic [FrameLenW-1:0] FrameLenRw1  = FrameLenW'(8);
  localparam logic [FrameLenW-1:0] FrameLenRw2  = FrameLenW'(9);
  localparam logic [FrameLenW-1:0] FrameLenMove = FrameLenW'(13);

  // Frame byte values
  localparam logic [7:0] HdrByte   = 8'hFF;
  localparam logic [7:0] LenRw1    = 8'h04;
  localparam logic [7:0] LenRw2    = 8'h05;
  localparam logic [7:0] LenMove   = 8'h09;
  localparam logic [7:0] InstRead  = 8'h02;
  localparam logic [7:0] InstWrite = 8'h03;
  localparam logic [7:0] MoveAddr  = 8'h2A;

  // Running sum start value: the two 0xFF header bytes add 0xFE, so a seed
  // of 0x02 leaves the sum at zero (mod 256) when the id byte goes out.
  localparam logic [7:0] ChkSeed = 8'h02;

  typedef enum logic [1:0] {
    KindRead   = 2'd0,
    KindWrite  = 2'd1,
    KindMove   = 2'd2,
    KindUnused = 2'd3
  } kind_e;

  // One command item as held before framing
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  servo_id;
    logic [7:0]  reg_addr;
    logic [1:0]  byte_count;
    logic [15:0] write_value;
    logic [15:0] target_position;
    logic [15:0] move_duration;
    logic [15:0] move_speed;
    logic        bus_select;
  } cmd_t;

  // Contents of one chain cell
  typedef struct packed {
    logic       vld;
    logic       chk;
    logic       bus;
    logic [7:0] data;
  } cell_t;

endpackage

`default_nettype wire

// ===== rtl/core/sbcf_cell.sv =====
// ============================================================================
// sbcf_cell - one byte cell of the frame chain
// Holds one frame byte; loads in parallel or takes its upstream neighbour.
// ============================================================================
`default_nettype none

module sbcf_cell (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               load_i,
  input  wire               shift_i,
  input  sbcf_pkg::cell_t   load_cell_i,
  input  sbcf_pkg::cell_t   next_cell_i,
  output sbcf_pkg::cell_t   cell_o
);

  logic       vld_q, vld_d;
  logic       chk_q, chk_d;
  logic       bus_q, bus_d;
  logic [7:0] data_q, data_d;

  // Load wins over shift; a load happens only as the old frame drains
  always_comb begin
    vld_d  = vld_q;
    chk_d  = chk_q;
    bus_d  = bus_q;
    data_d = data_q;
    if (load_i) begin
      vld_d  = load_cell_i.vld;
      chk_d  = load_cell_i.chk;
      bus_d  = load_cell_i.bus;
      data_d = load_cell_i.data;
    end else if (shift_i) begin
      vld_d  = next_cell_i.vld;
      chk_d  = next_cell_i.chk;
      bus_d  = next_cell_i.bus;
      data_d = next_cell_i.data;
    end
  end

  // Valid flag under reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    chk_q  <= chk_d;
    bus_q  <= bus_d;
    data_q <= data_d;
  end

  assign cell_o = '{vld: vld_q, chk: chk_q, bus: bus_q, data: data_q};

endmodule

`default_nettype wire

// ===== rtl/core/sbcf_frame_build.sv =====
// ============================================================================
// sbcf_frame_build - frame layout for one command
// Lays out header, body and checksum slot of a command across the chain.
// ============================================================================
`default_nettype none

module sbcf_frame_build (
  input  sbcf_pkg::cmd_t  cmd_i,
  output sbcf_pkg::cell_t cell_o [sbcf_pkg::FrameMax]
);

  logic [7:0]                     frame [sbcf_pkg::FrameMax];
  logic [sbcf_pkg::FrameLenW-1:0] len;
  logic [sbcf_pkg::FrameLenW-1:0] last;

  // Byte layout per kind; len of zero means no frame
  always_comb begin
    frame    = '{default: '0};
    len      = '0;
    frame[0] = sbcf_pkg::HdrByte;
    frame[1] = sbcf_pkg::HdrByte;
    frame[2] = cmd_i.servo_id;
    case (sbcf_pkg::kind_e'(cmd_i.kind))
      sbcf_pkg::KindRead: begin
        frame[3] = sbcf_pkg::LenRw1;
        frame[4] = sbcf_pkg::InstRead;
        frame[5] = cmd_i.reg_addr;
        frame[6] = {6'b0, cmd_i.byte_count};
        len      = sbcf_pkg::FrameLenRw1;
      end
      sbcf_pkg::KindWrite: begin
        frame[4] = sbcf_pkg::InstWrite;
        frame[5] = cmd_i.reg_addr;
        case (cmd_i.byte_count)
          2'd1: begin
            frame[3] = sbcf_pkg::LenRw1;
            frame[6] = cmd_i.write_value[7:0];
            len      = sbcf_pkg::FrameLenRw1;
          end
          2'd2: begin
            frame[3] = sbcf_pkg::LenRw2;
            // little-endian bus sends low byte first
            if (cmd_i.bus_select) begin
              frame[6] = cmd_i.write_value[7:0];
              frame[7] = cmd_i.write_value[15:8];
            end else begin
              frame[6] = cmd_i.write_value[15:8];
              frame[7] = cmd_i.write_value[7:0];
            end
            len      = sbcf_pkg::FrameLenRw2;
          end
          default: len = '0;
        endcase
      end
      sbcf_pkg::KindMove: begin
        frame[3]  = sbcf_pkg::LenMove;
        frame[4]  = sbcf_pkg::InstWrite;
        frame[5]  = sbcf_pkg::MoveAddr;
        frame[6]  = cmd_i.target_position[7:0];
        frame[7]  = cmd_i.target_position[15:8];
        frame[8]  = cmd_i.move_duration[7:0];
        frame[9]  = cmd_i.move_duration[15:8];
        frame[10] = cmd_i.move_speed[7:0];
        frame[11] = cmd_i.move_speed[15:8];
        len       = sbcf_pkg::FrameLenMove;
      end
      default: len = '0;
    endcase
  end

  assign last = len - sbcf_pkg::FrameLenW'(1);

  // Per-cell flags; the checksum slot is filled at the head from the running sum
  always_comb begin
    for (int k = 0; k < sbcf_pkg::FrameMax; k++) begin
      cell_o[k].vld  = sbcf_pkg::FrameLenW'(k) < len;
      cell_o[k].chk  = (sbcf_pkg::FrameLenW'(k) < len) && (sbcf_pkg::FrameLenW'(k) == last);
      cell_o[k].bus  = cmd_i.bus_select;
      cell_o[k].data = frame[k];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/servo_bus_command_framer_top.sv =====
// A taken command item is registered in the holding register, then loaded into the chain cells.
// Throughput: one byte per cycle while out_stall_i is low; read and one-byte write frames
//   are 8 bytes, two-byte writes 9 and moves 13, the longest filling the 13-cell shift chain.
// A held command loads as the previous checksum byte leaves, so frames follow
//   without a gap; one further command item is taken while a frame drains.
// Reset clears all valid flags and sets the running checksum to its seed.
// ============================================================================
// servo_bus_command_framer_top - servo bus command framer
// Takes servo commands and sends their bus frames one byte per item.
// ============================================================================
`default_nettype none

module servo_bus_command_framer_top (
  input  wire         clk_i,
  input  wire         rst_ni,
  // command channel
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  wire  [1:0]  kind_i,
  input  wire  [7:0]  servo_id_i,
  input  wire  [7:0]  reg_addr_i,
  input  wire  [1:0]  byte_count_i,
  input  wire  [15:0] write_value_i,
  input  wire  [15:0] target_position_i,
  input  wire  [15:0] move_duration_i,
  input  wire  [15:0] move_speed_i,
  input  wire         bus_select_i,
  // frame byte channel
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output logic        out_bus_o,
  output logic [7:0]  frame_byte_o,
  output logic        frame_end_o
);

  localparam int unsigned N = sbcf_pkg::FrameMax;

  sbcf_pkg::cmd_t  hold_q;
  logic            hold_valid_q, hold_valid_d;
  sbcf_pkg::cell_t load_cell [N];
  sbcf_pkg::cell_t chain [N];
  logic [N-1:0]    vld_vec;
  logic [7:0]      acc_q, acc_d;
  logic            in_take;
  logic            head_take;
  logic            load;

  // Command holding register
  assign in_stall_o = hold_valid_q;
  assign in_take    = in_valid_i && !hold_valid_q;

  always_comb begin
    hold_valid_d = hold_valid_q;
    if (in_take) begin
      hold_valid_d = 1'b1;
    end else if (load) begin
      hold_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
    end else begin
      hold_valid_q <= hold_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      hold_q <= '{kind: kind_i, servo_id: servo_id_i, reg_addr: reg_addr_i,
                  byte_count: byte_count_i, write_value: write_value_i,
                  target_position: target_position_i, move_duration: move_duration_i,
                  move_speed: move_speed_i, bus_select: bus_select_i};
    end
  end

  // Frame layout of the held command
  sbcf_frame_build u_build (
    .cmd_i  (hold_q),
    .cell_o (load_cell)
  );

  // Load when the chain is empty or its last byte is leaving the head
  always_comb begin
    for (int k = 0; k < N; k++) begin
      vld_vec[k] = chain[k].vld;
    end
  end

  assign head_take = chain[0].vld && !out_stall_i;
  assign load      = hold_valid_q && !(|vld_vec[N-1:1]) && (!chain[0].vld || head_take);

  // Chain of byte cells, shifting toward the head
  for (genvar k = 0; k < N; k++) begin : g_cell
    sbcf_pkg::cell_t next_cell;
    if (k == N - 1) begin : g_tail
      assign next_cell = '0;
    end else begin : g_mid
      assign next_cell = chain[k+1];
    end
    sbcf_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .load_i      (load),
      .shift_i     (head_take),
      .load_cell_i (load_cell[k]),
      .next_cell_i (next_cell),
      .cell_o      (chain[k])
    );
  end

  // Running checksum over bytes that have left the head
  always_comb begin
    acc_d = acc_q;
    if (head_take) begin
      if (chain[0].chk) begin
        acc_d = sbcf_pkg::ChkSeed;
      end else begin
        acc_d = acc_q + chain[0].data;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= sbcf_pkg::ChkSeed;
    end else begin
      acc_q <= acc_d;
    end
  end

  // Head cell drives the output
  assign out_valid_o  = chain[0].vld;
  assign out_bus_o    = chain[0].bus;
  assign frame_end_o  = chain[0].chk;
  assign frame_byte_o = chain[0].chk ? ~acc_q : chain[0].data;

  // Valid cells always form one run from the head
  a_chain_packed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |-> ((vld_vec & (vld_vec + N'(1))) == '0))
    else $error("chain holds a gap between valid cells");

  // A frame never breaks off before its checksum byte
  a_frame_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !frame_end_o) |=> out_valid_o)
    else $error("frame ended without a checksum byte");

  // Running sum restarts after each checksum byte
  a_acc_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && frame_end_o) |=> (acc_q == sbcf_pkg::ChkSeed))
    else $error("checksum accumulator not restarted");

  // A held command waits until it is loaded
  a_hold_keep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hold_valid_q && !load) |=> (hold_valid_q && $stable(hold_q)))
    else $error("held command lost before load");

  // Loading only into a drained chain
  a_load_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> ($countones(vld_vec[N-1:1]) == 0))
    else $error("frame loaded over a busy chain");

endmodule

`default_nettype wire

// ===== tb/sbcf_frame_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// sbcf_frame_checker - frame predictor and byte checker for the servo framer
// Watches both channels of the framer. Each accepted command is turned into
// its expected bus frame; each accepted frame byte is checked against the
// oldest expected byte, field by field.
// ============================================================================

module sbcf_frame_checker (
  input  wire         clk_i,
  input  wire         rst_ni,
  // command channel
  input  wire         in_valid_i,
  input  wire         in_stall_i,
  input  wire  [1:0]  kind_i,
  input  wire  [7:0]  servo_id_i,
  input  wire  [7:0]  reg_addr_i,
  input  wire  [1:0]  byte_count_i,
  input  wire  [15:0] write_value_i,
  input  wire  [15:0] target_position_i,
  input  wire  [15:0] move_duration_i,
  input  wire  [15:0] move_speed_i,
  input  wire         bus_select_i,
  // frame byte channel
  input  wire         out_valid_i,
  input  wire         out_stall_i,
  input  wire         out_bus_i,
  input  wire  [7:0]  frame_byte_i,
  input  wire         frame_end_i,
  // status towards the testbench top
  output int unsigned mismatch_count_o,
  output int unsigned pending_bytes_o
);

  // Protocol byte values
  localparam logic [7:0] SyncByte    = 8'hFF;
  localparam logic [7:0] LenShort    = 8'h04;
  localparam logic [7:0] LenPair     = 8'h05;
  localparam logic [7:0] LenMove     = 8'h09;
  localparam logic [7:0] OpRead      = 8'h02;
  localparam logic [7:0] OpWrite     = 8'h03;
  localparam logic [7:0] GoalRegAddr = 8'h2A;
  localparam logic [1:0] CountOne    = 2'd1;
  localparam logic [1:0] CountTwo    = 2'd2;

  typedef struct packed {
    logic       bus;
    logic [7:0] data;
    logic       last;
  } frame_byte_t;

  frame_byte_t     expected_bytes[$];
  sbcf_pkg::cmd_t  cmd;

  initial begin
    mismatch_count_o = 0;
    pending_bytes_o  = 0;
  end

  assign cmd = '{kind: kind_i, servo_id: servo_id_i, reg_addr: reg_addr_i,
                 byte_count: byte_count_i, write_value: write_value_i,
                 target_position: target_position_i, move_duration: move_duration_i,
                 move_speed: move_speed_i, bus_select: bus_select_i};

  // Build the frame of one command and queue its bytes
  function automatic void frame_command(input sbcf_pkg::cmd_t c);
    logic [7:0]  body [10];
    int unsigned body_len;
    logic [7:0]  sum;
    body_len = 0;
    sum      = 8'd0;
    body[0]  = c.servo_id;
    case (c.kind)
      sbcf_pkg::KindRead: begin
        body[1]  = LenShort;
        body[2]  = OpRead;
        body[3]  = c.reg_addr;
        // count goes out as given, even when out of range
        body[4]  = {6'd0, c.byte_count};
        body_len = 5;
      end
      sbcf_pkg::KindWrite: begin
        body[2] = OpWrite;
        body[3] = c.reg_addr;
        if (c.byte_count == CountOne) begin
          body[1]  = LenShort;
          body[4]  = c.write_value[7:0];
          body_len = 5;
        end else if (c.byte_count == CountTwo) begin
          body[1] = LenPair;
          // little-endian bus sends low byte first
          if (c.bus_select) begin
            body[4] = c.write_value[7:0];
            body[5] = c.write_value[15:8];
          end else begin
            body[4] = c.write_value[15:8];
            body[5] = c.write_value[7:0];
          end
          body_len = 6;
        end
      end
      sbcf_pkg::KindMove: begin
        body[1]  = LenMove;
        body[2]  = OpWrite;
        body[3]  = GoalRegAddr;
        body[4]  = c.target_position[7:0];
        body[5]  = c.target_position[15:8];
        body[6]  = c.move_duration[7:0];
        body[7]  = c.move_duration[15:8];
        body[8]  = c.move_speed[7:0];
        body[9]  = c.move_speed[15:8];
        body_len = 10;
      end
      default: body_len = 0;
    endcase
    // unused kind and bad write counts send nothing
    if (body_len == 0) return;
    expected_bytes.push_back('{bus: c.bus_select, data: SyncByte, last: 1'b0});
    expected_bytes.push_back('{bus: c.bus_select, data: SyncByte, last: 1'b0});
    for (int i = 0; i < body_len; i++) begin
      sum += body[i];
      expected_bytes.push_back('{bus: c.bus_select, data: body[i], last: 1'b0});
    end
    expected_bytes.push_back('{bus: c.bus_select, data: ~sum, last: 1'b1});
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] want,
                                 input logic [7:0] got);
    $display("%0t: mismatch on %s: expected %02h, got %02h", $realtime, what, want, got);
    mismatch_count_o++;
  endtask

  // Predict on accepted commands, compare on accepted frame bytes
  always @(posedge clk_i) begin
    frame_byte_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_i) frame_command(cmd);
      if (out_valid_i && !out_stall_i) begin
        if (expected_bytes.size() == 0) begin
          report_mismatch("unexpected frame byte", 8'h00, frame_byte_i);
        end else begin
          want = expected_bytes.pop_front();
          if (out_bus_i !== want.bus) begin
            report_mismatch("out_bus", {7'd0, want.bus}, {7'd0, out_bus_i});
          end
          if (frame_byte_i !== want.data) report_mismatch("frame_byte", want.data, frame_byte_i);
          if (frame_end_i !== want.last) begin
            report_mismatch("frame_end", {7'd0, want.last}, {7'd0, frame_end_i});
          end
        end
      end
    end
    pending_bytes_o <= expected_bytes.size();
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ============================================================================
// testbench - servo bus command framer
// Sends directed and random servo commands with random gaps and output
// stalls; the frame checker predicts every frame and checks each byte.
// ============================================================================

module testbench;

  localparam int unsigned RandomItems = 191;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned CycleLimit  = 200000;

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           in_valid = 1'b0;
  sbcf_pkg::cmd_t cmd = '0;
  logic           out_stall = 1'b1;
  logic           in_gaps_on = 1'b1;
  logic           out_gaps_on = 1'b1;
  int unsigned    cycle_count = 0;

  wire         in_stall;
  wire         out_valid;
  wire         out_bus;
  wire  [7:0]  frame_byte;
  wire         frame_end;
  int unsigned mismatch_count;
  int unsigned pending_bytes;

  servo_bus_command_framer_top dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .kind_i            (cmd.kind),
    .servo_id_i        (cmd.servo_id),
    .reg_addr_i        (cmd.reg_addr),
    .byte_count_i      (cmd.byte_count),
    .write_value_i     (cmd.write_value),
    .target_position_i (cmd.target_position),
    .move_duration_i   (cmd.move_duration),
    .move_speed_i      (cmd.move_speed),
    .bus_select_i      (cmd.bus_select),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .out_bus_o         (out_bus),
    .frame_byte_o      (frame_byte),
    .frame_end_o       (frame_end)
  );

  sbcf_frame_checker checker_i (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_stall_i        (in_stall),
    .kind_i            (cmd.kind),
    .servo_id_i        (cmd.servo_id),
    .reg_addr_i        (cmd.reg_addr),
    .byte_count_i      (cmd.byte_count),
    .write_value_i     (cmd.write_value),
    .target_position_i (cmd.target_position),
    .move_duration_i   (cmd.move_duration),
    .move_speed_i      (cmd.move_speed),
    .bus_select_i      (cmd.bus_select),
    .out_valid_i       (out_valid),
    .out_stall_i       (out_stall),
    .out_bus_i         (out_bus),
    .frame_byte_i      (frame_byte),
    .frame_end_i       (frame_end),
    .mismatch_count_o  (mismatch_count),
    .pending_bytes_o   (pending_bytes)
  );

  // Clock
  initial begin
    forever #5 clk = ~clk;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("testbench failed");
      $finish;
    end
  end

  // Switch idling on and off in stretches for each side
  initial begin
    forever begin
      repeat ($urandom_range(20, 150)) @(posedge clk);
      in_gaps_on  <= ($urandom_range(0, 3) != 0);
      out_gaps_on <= ($urandom_range(0, 3) != 0);
    end
  end

  // Frame byte receiver: random stall before each item
  initial begin
    int unsigned gap;
    forever begin
      gap = out_gaps_on ? $urandom_range(0, 3) : 0;
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  function automatic sbcf_pkg::cmd_t random_fields();
    sbcf_pkg::cmd_t c;
    c.kind            = 2'($urandom);
    c.servo_id        = 8'($urandom);
    c.reg_addr        = 8'($urandom);
    c.byte_count      = 2'($urandom);
    c.write_value     = 16'($urandom);
    c.target_position = 16'($urandom);
    c.move_duration   = 16'($urandom);
    c.move_speed      = 16'($urandom);
    c.bus_select      = 1'($urandom);
    return c;
  endfunction

  function automatic sbcf_pkg::cmd_t make_command(input sbcf_pkg::kind_e kind,
                                        input logic [7:0] id,
                                        input logic [7:0] addr, input logic [1:0] cnt,
                                        input logic [15:0] wval, input logic [15:0] pos,
                                        input logic [15:0] dur, input logic [15:0] spd,
                                        input logic bus);
    sbcf_pkg::cmd_t c;
    c = '{kind: kind, servo_id: id, reg_addr: addr, byte_count: cnt, write_value: wval,
          target_position: pos, move_duration: dur, move_speed: spd, bus_select: bus};
    return c;
  endfunction

  // Offer one command after a random gap and hold it until taken
  task automatic send_command(input sbcf_pkg::cmd_t c);
    int unsigned gap;
    gap = in_gaps_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd      <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Stimulus and verdict
  initial begin
    sbcf_pkg::cmd_t c;
    int unsigned    pick;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reads: extremes and out-of-range counts
    send_command(make_command(sbcf_pkg::KindRead, 8'h00, 8'h00, 2'd1, 16'hFFFF, 16'hFFFF,
                              16'hFFFF, 16'hFFFF, 1'b0));
    send_command(make_command(sbcf_pkg::KindRead, 8'hFF, 8'hFF, 2'd2, 16'h0000, 16'h0000,
                              16'h0000, 16'h0000, 1'b1));
    send_command(make_command(sbcf_pkg::KindRead, 8'h5A, 8'h38, 2'd0, 16'h1234, 16'h0000,
                              16'h0000, 16'h0000, 1'b0));
    send_command(make_command(sbcf_pkg::KindRead, 8'hA5, 8'hC7, 2'd3, 16'h0000, 16'h0000,
                              16'h0000, 16'h0000, 1'b1));
    // one-byte and two-byte writes on both buses
    send_command(make_command(sbcf_pkg::KindWrite, 8'h00, 8'h00, 2'd1, 16'h0000, 16'hFFFF,
                              16'hFFFF, 16'hFFFF, 1'b0));
    send_command(make_command(sbcf_pkg::KindWrite, 8'hFF, 8'hFF, 2'd1, 16'hFFFF, 16'h0000,
                              16'h0000, 16'h0000, 1'b1));
    send_command(make_command(sbcf_pkg::KindWrite, 8'h01, 8'h2A, 2'd2, 16'h1234, 16'h0000,
                              16'h0000, 16'h0000, 1'b0));
    send_command(make_command(sbcf_pkg::KindWrite, 8'h01, 8'h2A, 2'd2, 16'h1234, 16'h0000,
                              16'h0000, 16'h0000, 1'b1));
    send_command(make_command(sbcf_pkg::KindWrite, 8'hFE, 8'h80, 2'd2, 16'hFFFF, 16'h0000,
                              16'h0000, 16'h0000, 1'b0));
    send_command(make_command(sbcf_pkg::KindWrite, 8'h7F, 8'h7F, 2'd2, 16'h0000, 16'hFFFF,
                              16'hFFFF, 16'hFFFF, 1'b1));
    // writes with a bad count send nothing
    send_command(make_command(sbcf_pkg::KindWrite, 8'h11, 8'h22, 2'd0, 16'hBEEF, 16'h0000,
                              16'h0000, 16'h0000, 1'b0));
    send_command(make_command(sbcf_pkg::KindWrite, 8'h33, 8'h44, 2'd3, 16'hCAFE, 16'h0000,
                              16'h0000, 16'h0000, 1'b1));
    // moves
    send_command(make_command(sbcf_pkg::KindMove, 8'h00, 8'hFF, 2'd3, 16'hFFFF, 16'h0000,
                              16'h0000, 16'h0000, 1'b0));
    send_command(make_command(sbcf_pkg::KindMove, 8'hFF, 8'h00, 2'd0, 16'h0000, 16'hFFFF,
                              16'hFFFF, 16'hFFFF, 1'b1));
    send_command(make_command(sbcf_pkg::KindMove, 8'h9C, 8'h12, 2'd1, 16'h5555, 16'h1234,
                              16'h5678, 16'h9ABC, 1'b0));
    send_command(make_command(sbcf_pkg::KindMove, 8'h9C, 8'h12, 2'd2, 16'hAAAA, 16'h1234,
                              16'h5678, 16'h9ABC, 1'b1));
    // unused kind sends nothing, then a frame must still follow cleanly
    send_command(make_command(sbcf_pkg::KindUnused, 8'hFF, 8'hFF, 2'd2, 16'hFFFF, 16'hFFFF,
                              16'hFFFF, 16'hFFFF, 1'b1));
    send_command(make_command(sbcf_pkg::KindUnused, 8'h00, 8'h00, 2'd1, 16'h0000, 16'h0000,
                              16'h0000, 16'h0000, 1'b0));
    send_command(make_command(sbcf_pkg::KindRead, 8'h42, 8'h24, 2'd1, 16'h0000, 16'h0000,
                              16'h0000, 16'h0000, 1'b1));

    // Random commands, mostly well formed
    for (int unsigned n = 0; n < RandomItems; n++) begin
      c    = random_fields();
      pick = $urandom_range(0, 99);
      if (pick < 30)      c.kind = sbcf_pkg::KindRead;
      else if (pick < 65) c.kind = sbcf_pkg::KindWrite;
      else if (pick < 95) c.kind = sbcf_pkg::KindMove;
      else                c.kind = sbcf_pkg::KindUnused;
      // counts out of range only now and then
      if ($urandom_range(0, 9) != 0) c.byte_count = 2'($urandom_range(1, 2));
      send_command(c);
    end
    in_valid <= 1'b0;

    // Wait for every expected byte, then watch for stray ones
    @(posedge clk);
    while (pending_bytes != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (mismatch_count == 0 && pending_bytes == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
